@@ rtl/core/utf8_stream_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared concurrent assertion forms; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define U8SD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define U8SD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define U8SD_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define U8SD_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/core/u8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Queue entry type and the scalar range constants shared by the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

  // One classified input byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       eot;
    logic [2:0] lead_len;  // sequence length for a lead byte, 0 if not a lead
    logic       is_cont;   // byte has the 10xxxxxx continuation form
  } q_entry_t;

  // Scalar value limits.
  localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;

  // Smallest value that each sequence length may carry.
  localparam logic [20:0] MIN_CODE2  = 21'h000080;
  localparam logic [20:0] MIN_CODE3  = 21'h000800;
  localparam logic [20:0] MIN_CODE4  = 21'h010000;

  // Continuation byte form.
  localparam logic [7:0]  CONT_MASK  = 8'hC0;
  localparam logic [7:0]  CONT_TAG   = 8'h80;

endpackage

`default_nettype wire

@@ rtl/core/u8sd_front.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder front end
// Takes input bytes and classifies each one as a lead or continuation byte.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_front (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        data_byte,
  input  wire logic              end_of_text,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output u8sd_pkg::q_entry_t     push_data
);

  // Lead byte tags in their top bits.
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  // Sequence length announced by a byte, zero for anything that cannot lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (!b[7]) begin
      len = 3'd1;
    end else if (b[7:5] == LEAD2_TAG) begin
      len = 3'd2;
    end else if (b[7:4] == LEAD3_TAG) begin
      len = 3'd3;
    end else if (b[7:3] == LEAD4_TAG) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // A transfer on the input goes straight into the queue.
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  // Classification done once per byte, so the back end only selects.
  always_comb begin
    push_data.data     = data_byte;
    push_data.eot      = end_of_text;
    push_data.lead_len = lead_len(data_byte);
    push_data.is_cont  = (data_byte & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_TAG;
  end

endmodule

`default_nettype wire

@@ rtl/core/u8sd_queue.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder queue
// Small FIFO of classified bytes between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire u8sd_pkg::q_entry_t push_data,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output u8sd_pkg::q_entry_t      pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8sd_pkg::q_entry_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               push;
  logic               pop;

  assign push_ready = fill != CNT_W'(DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage, written on every push transfer.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/u8sd_back.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder back end
// Holds pending bytes, decodes one scalar per cycle while the output is free and drives the output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module u8sd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire u8sd_pkg::q_entry_t q_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [20:0]             code_point,
  output logic [2:0]              byte_count,
  output logic [31:0]             raw_bytes,
  output logic                    last_of_run
);

  // Held bytes; active means the current byte still owes results.
  u8sd_pkg::q_entry_t buf_ent [4];
  logic [2:0]         cnt;
  logic               eot_r;
  logic               active;

  // Working view: held bytes plus the newly taken byte.
  u8sd_pkg::q_entry_t cur_ent [4];
  logic [2:0]         cur_cnt;
  logic               cur_eot;
  logic               have;
  logic               out_free;

  // Decode results at the head.
  logic [2:0]         len0;
  logic [20:0]        code;
  logic [20:0]        minc;
  logic               cont_ok;
  logic               full;
  logic               ok;
  logic               wait0;
  logic [2:0]         use_len;
  logic [20:0]        res_code;
  logic [31:0]        res_raw;
  logic [2:0]         rem;
  u8sd_pkg::q_entry_t nxt;
  logic               last;
  u8sd_pkg::q_entry_t shifted [4];

  // A new byte is taken from the queue whenever the previous one is done.
  assign q_ready  = !active;
  assign have     = active || q_valid;
  assign out_free = !out_valid || out_ready;

  // Append the incoming byte behind the held ones.
  always_comb begin
    cur_ent = buf_ent;
    cur_cnt = cnt;
    cur_eot = eot_r;
    if (!active) begin
      cur_ent[cnt[1:0]] = q_data;
      cur_cnt           = cnt + 3'd1;
      cur_eot           = q_data.eot;
    end
  end

  // Assemble the candidate scalar for the head lead byte.
  always_comb begin
    len0 = cur_ent[0].lead_len;
    unique case (len0)
      3'd1: begin
        code    = {13'd0, cur_ent[0].data};
        minc    = '0;
        cont_ok = 1'b1;
      end
      3'd2: begin
        code    = {10'd0, cur_ent[0].data[4:0], cur_ent[1].data[5:0]};
        minc    = u8sd_pkg::MIN_CODE2;
        cont_ok = cur_ent[1].is_cont;
      end
      3'd3: begin
        code    = {5'd0, cur_ent[0].data[3:0], cur_ent[1].data[5:0],
                   cur_ent[2].data[5:0]};
        minc    = u8sd_pkg::MIN_CODE3;
        cont_ok = cur_ent[1].is_cont && cur_ent[2].is_cont;
      end
      3'd4: begin
        code    = {cur_ent[0].data[2:0], cur_ent[1].data[5:0],
                   cur_ent[2].data[5:0], cur_ent[3].data[5:0]};
        minc    = u8sd_pkg::MIN_CODE4;
        cont_ok = cur_ent[1].is_cont && cur_ent[2].is_cont && cur_ent[3].is_cont;
      end
      default: begin
        code    = {13'd0, cur_ent[0].data};
        minc    = '0;
        cont_ok = 1'b0;
      end
    endcase
  end

  // Verdict, consumed length and the look at the following byte.
  always_comb begin
    logic [2:0] sidx;
    full     = (len0 != 3'd0) && (cur_cnt >= len0);
    ok       = full && cont_ok && (code >= minc)
               && !((code >= u8sd_pkg::SURR_LO) && (code <= u8sd_pkg::SURR_HI))
               && (code <= u8sd_pkg::MAX_SCALAR);
    // A valid lead still short of bytes waits unless the text has ended.
    wait0    = (len0 != 3'd0) && (cur_cnt < len0) && !cur_eot;
    use_len  = ok ? len0 : 3'd1;
    res_code = ok ? code : {13'd0, cur_ent[0].data};
    for (int k = 0; k < 4; k++) begin
      res_raw[8*k +: 8] = (3'(k) < use_len) ? cur_ent[k].data : 8'h00;
    end
    rem  = cur_cnt - use_len;
    nxt  = cur_ent[use_len[1:0]];
    last = (rem == 3'd0)
           || ((nxt.lead_len != 3'd0) && (rem < nxt.lead_len) && !cur_eot);
    for (int i = 0; i < 4; i++) begin
      sidx       = 3'(i) + use_len;
      shifted[i] = (sidx < 3'd4) ? cur_ent[sidx[1:0]] : cur_ent[i];
    end
  end

  // Held byte storage, not reset.
  always_ff @(posedge clk) begin
    if (have) begin
      eot_r <= cur_eot;
      if (!wait0 && out_free) begin
        buf_ent <= shifted;
      end else begin
        buf_ent <= cur_ent;
      end
    end
  end

  // Count, activity and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= 3'd0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A new result takes the output register; otherwise a taken one clears.
      if (have && !wait0 && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (have) begin
        if (wait0) begin
          cnt    <= cur_cnt;
          active <= 1'b0;
        end else if (out_free) begin
          cnt    <= rem;
          active <= !last;
        end else begin
          cnt    <= cur_cnt;
          active <= 1'b1;
        end
      end
    end
  end

  // Result payload, loaded on each emitted scalar.
  always_ff @(posedge clk) begin
    if (have && !wait0 && out_free) begin
      code_point  <= res_code;
      byte_count  <= use_len;
      raw_bytes   <= res_raw;
      last_of_run <= last;
    end
  end

  `U8SD_ASSERT_IMP(a_idle_cnt, clk, rst, !active, cnt <= 3'd3, "idle with more than three held bytes")
  `U8SD_ASSERT_IMP(a_active_cnt, clk, rst, active, cnt != 3'd0, "active with no held bytes")
  `U8SD_ASSERT_IMP(a_out_len, clk, rst, out_valid, (byte_count != 3'd0) && (byte_count <= 3'd4), "result byte count out of range")
  `U8SD_ASSERT_NEXT(a_wait_idle, clk, rst, have && wait0, !active, "waiting byte left the decoder active")

endmodule

`default_nettype wire

@@ rtl/core/utf8_stream_decoder.sv @@
// Path: a byte is registered in the queue, then decoded and its result registered at the output.
// Throughput: one result per cycle from the back end's single decode stage while the output is free;
// a byte may yield up to four results, and no new byte is taken until the last of them is out,
// while a byte that completes no sequence yet yields none and is held.
// Reset: synchronous, clears the queue, the held byte count and out_valid;
// held byte values are not reset and are never read before being written.
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream into scalars, replaying bad sequences byte by byte.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_text,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [20:0]      code_point,
  output logic [2:0]       byte_count,
  output logic [31:0]      raw_bytes,
  output logic             last_of_run
);

  logic               push_valid;
  logic               push_ready;
  u8sd_pkg::q_entry_t push_data;
  logic               pop_valid;
  logic               pop_ready;
  u8sd_pkg::q_entry_t pop_data;

  // Byte intake and classification.
  u8sd_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .end_of_text (end_of_text),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  // Decoupling queue.
  u8sd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Sequence decode and output.
  u8sd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (pop_valid),
    .q_ready     (pop_ready),
    .q_data      (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .byte_count  (byte_count),
    .raw_bytes   (raw_bytes),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
